@@ src/assert_macros.svh @@
// Assertion helpers shared by the RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Assert that a property holds on every clock edge outside reset
`define ASSERT_CLK(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("assertion failed");

// Assert that an antecedent implies a consequent in the next cycle
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

@@ src/ncpu_pkg.sv @@
package ncpu_pkg;
	localparam int unsigned ROM_DEPTH_DEF   = 4096;
	localparam int unsigned RAM_DEPTH_DEF   = 256;
	localparam int unsigned STACK_DEPTH_DEF = 64;
	localparam int unsigned MAX_BUDGET_DEF  = 64;
	localparam logic [7:0]  IO_ADDR_RST     = 8'hFF;

	typedef enum logic [3:0] {
		OP_LDA = 4'd0, OP_STA = 4'd1, OP_ADD = 4'd2, OP_OR = 4'd3,
		OP_AND = 4'd4, OP_NOT = 4'd5, OP_SHL = 4'd6, OP_SHR = 4'd7,
		OP_PUA = 4'd8, OP_POA = 4'd9, OP_CMP = 4'd10, OP_JZ = 4'd11,
		OP_JC = 4'd12, OP_SED = 4'd13, OP_SES = 4'd14, OP_TRR = 4'd15
	} opcode_t;

	localparam logic FUNC_LOAD = 1'b0;
	localparam logic FUNC_RUN  = 1'b1;
	localparam logic KIND_WRITE = 1'b0;
	localparam logic KIND_END   = 1'b1;

	function automatic logic [3:0] op_cost(input logic [3:0] op);
		logic [3:0] c;
		case (op)
			OP_LDA, OP_STA, OP_NOT, OP_SHL, OP_SHR: c = 4'd2;
			OP_OR, OP_AND:                          c = 4'd3;
			OP_ADD, OP_PUA, OP_POA, OP_CMP:         c = 4'd4;
			OP_JZ, OP_JC:                           c = 4'd8;
			OP_SED:                                 c = 4'd5;
			OP_SES:                                 c = 4'd7;
			default:                                c = 4'd6;
		endcase
		return c;
	endfunction
endpackage

@@ src/nibble_cpu_core.sv @@
// Nibble CPU core.
// Configuration: io_wr_en / io_wr_data write the I/O data address (reset 255);
// the user must write it only while busy is low, the core does not enforce this.
// Commands: a transaction is accepted when start is high and busy is low.
// func 0 writes one program nibble and yields a single end result.
// func 1 runs instructions until the cycle budget is spent, the program halts
// or a store to the I/O address with io_write_stop set stops it; each store or
// transfer to the I/O address yields one write result, then one end result.
// Results appear for one cycle with res_valid; the receiver cannot stall.
// After reset a clearing pass over the deepest memory zeroes the program, data
// and stack memories; busy stays high meanwhile. A load passes through S_LOAD
// and S_END, and res_valid is registered from S_END. A run checks the budget,
// fetches the opcode, then either waits on the data memory or reads each
// operand nibble in turn, and executes; after the final budget check it ends in
// S_END. The next transaction can be accepted in the cycle that shows the end
// result. The memories have a registered read port, so each nibble fetch and
// data access waits on its memory in its own state (S_FETCH, S_OPR, S_DREQ).
// Asynchronous reset clears registers and starts the clearing pass.
module nibble_cpu_core
	import ncpu_pkg::*;
#(
	parameter int unsigned ROM_DEPTH   = ROM_DEPTH_DEF,
	parameter int unsigned RAM_DEPTH   = RAM_DEPTH_DEF,
	parameter int unsigned STACK_DEPTH = STACK_DEPTH_DEF,
	parameter int unsigned MAX_BUDGET  = MAX_BUDGET_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        io_wr_en,
	input  logic [7:0]  io_wr_data,
	input  logic        start,
	output logic        busy,
	input  logic        func,
	input  logic [11:0] load_address,
	input  logic [3:0]  load_nibble,
	input  logic [6:0]  cycle_budget,
	input  logic [3:0]  io_read_value,
	input  logic        io_write_stop,
	output logic        res_valid,
	output logic        kind,
	output logic [3:0]  io_write_value,
	output logic        last,
	output logic [3:0]  accumulator_out,
	output logic        zero_out,
	output logic        carry_out,
	output logic [12:0] pc_out,
	output logic        done_res,
	output logic [6:0]  cycles_used
);
	`include "assert_macros.svh"

	localparam int RW = $clog2(ROM_DEPTH);
	localparam int DW = $clog2(RAM_DEPTH);
	localparam int SW = $clog2(STACK_DEPTH);
	localparam int BW = $clog2(MAX_BUDGET + 16);
	localparam int unsigned CLR_DEPTH = (ROM_DEPTH > RAM_DEPTH)
		? ((ROM_DEPTH > STACK_DEPTH) ? ROM_DEPTH : STACK_DEPTH)
		: ((RAM_DEPTH > STACK_DEPTH) ? RAM_DEPTH : STACK_DEPTH);
	localparam int CLRW = $clog2(CLR_DEPTH);

	typedef enum logic [12:0] {
		S_CLEAR = 13'h0001, S_IDLE = 13'h0002, S_FETCH = 13'h0004,
		S_OPW = 13'h0008, S_OPR1 = 13'h0010, S_OPW1 = 13'h0020,
		S_DREQ = 13'h0040, S_DW = 13'h0080, S_EXEC = 13'h0100,
		S_CHK = 13'h0200, S_END = 13'h0400, S_LOAD = 13'h0800,
		S_OPR = 13'h1000
	} state_t;

	state_t     st_q;
	logic [7:0] io_addr_q;
	logic [3:0] acc_q;
	logic       z_q, c_q, halted_q, stop_q;
	logic [12:0] pc_q, back_q;
	logic [7:0] dp_q;
	logic [SW-1:0] sp_q;
	logic [11:0] src_q;
	logic [3:0] op_q;
	logic [11:0] opnd_q;
	logic [1:0] nleft_q;
	logic [RW-1:0] rd_addr_q;
	logic [BW-1:0] cnt_q, bud_q;
	logic [3:0] io_val_q;
	logic       io_stop_q;
	logic [CLRW:0] clr_q;

	// memory ports
	logic rom_we, ram_we, stk_we;
	logic [RW-1:0] rom_wa, rom_ra;
	logic [3:0] rom_wd, rom_rd, ram_wd, ram_rd, stk_wd, stk_rd;
	logic [DW-1:0] ram_wa, ram_ra;
	logic [SW-1:0] stk_wa, stk_ra;

	ncpu_ram #(.WIDTH(4), .DEPTH(ROM_DEPTH)) u_rom (
		.clk(clk), .we(rom_we), .waddr(rom_wa), .wdata(rom_wd),
		.raddr(rom_ra), .rdata(rom_rd));
	ncpu_ram #(.WIDTH(4), .DEPTH(RAM_DEPTH)) u_ram (
		.clk(clk), .we(ram_we), .waddr(ram_wa), .wdata(ram_wd),
		.raddr(ram_ra), .rdata(ram_rd));
	ncpu_ram #(.WIDTH(4), .DEPTH(STACK_DEPTH)) u_stk (
		.clk(clk), .we(stk_we), .waddr(stk_wa), .wdata(stk_wd),
		.raddr(stk_ra), .rdata(stk_rd));

	logic is_io;
	logic [DW-1:0] dp_idx;
	logic [SW-1:0] sp_dec;
	logic [4:0] sum;
	logic [3:0] dval;
	logic [3:0] res_acc;
	logic [12:0] pc_next;
	logic res_fire;
	logic halt_now;
	assign is_io  = (dp_q == io_addr_q);
	assign dp_idx = dp_q[DW-1:0];
	assign sp_dec = (sp_q == '0) ? SW'(STACK_DEPTH - 1) : sp_q - 1'b1;
	assign dval   = is_io ? io_val_q : ram_rd;
	assign sum    = {1'b0, acc_q} + {1'b0, dval};
	assign busy   = (st_q != S_IDLE);

	// immediate logic result and jump target
	assign res_acc = (op_q == OP_OR) ? (acc_q | opnd_q[3:0]) : (acc_q & opnd_q[3:0]);
	assign pc_next = ((op_q == OP_JZ && z_q) || (op_q == OP_JC && c_q))
		? {1'b0, opnd_q} : pc_q;

	// result strobe and finish detection
	assign res_fire = (st_q == S_END) ||
		(st_q == S_EXEC && is_io && (op_q == OP_STA || op_q == OP_TRR));
	assign halt_now = !(op_q == OP_STA && is_io && io_stop_q) &&
		(back_q == pc_next || pc_next >= 13'(ROM_DEPTH));

	// address and write control for the memories
	always_comb begin
		rom_we = 1'b0; rom_wa = rd_addr_q; rom_wd = 4'd0;
		ram_we = 1'b0; ram_wa = dp_idx; ram_wd = acc_q;
		stk_we = 1'b0; stk_wa = sp_q; stk_wd = acc_q;
		rom_ra = rd_addr_q;
		ram_ra = dp_idx;
		stk_ra = sp_dec;
		if (st_q == S_CLEAR) begin
			rom_we = 1'b1; rom_wa = clr_q[RW-1:0];
			ram_we = 1'b1; ram_wa = clr_q[DW-1:0]; ram_wd = 4'd0;
			stk_we = 1'b1; stk_wa = clr_q[SW-1:0]; stk_wd = 4'd0;
		end else if (st_q == S_IDLE && start && func == FUNC_LOAD) begin
			rom_we = 1'b1; rom_wa = load_address[RW-1:0]; rom_wd = load_nibble;
		end else if (st_q == S_EXEC) begin
			unique case (op_q)
				OP_STA: ram_we = 1'b1;
				OP_PUA: stk_we = 1'b1;
				OP_TRR: begin ram_we = 1'b1; ram_wd = rom_rd; end
				default: ;
			endcase
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_CLEAR; clr_q <= '0; io_addr_q <= IO_ADDR_RST;
			acc_q <= '0; z_q <= 1'b0; c_q <= 1'b0; halted_q <= 1'b0;
			pc_q <= '0; dp_q <= '0; sp_q <= '0; src_q <= '0;
			res_valid <= 1'b0; stop_q <= 1'b0; cnt_q <= '0;
			kind <= KIND_WRITE; io_write_value <= '0; last <= 1'b0;
			bud_q <= '0; io_val_q <= '0; io_stop_q <= 1'b0;
			rd_addr_q <= '0; back_q <= '0; op_q <= '0; opnd_q <= '0;
			nleft_q <= '0;
		end else begin
			res_valid <= res_fire;
			if (io_wr_en)
				io_addr_q <= io_wr_data;
			unique case (st_q)
				S_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == (CLRW+1)'(CLR_DEPTH - 1))
						st_q <= S_IDLE;
				end
				S_IDLE: if (start) begin
					if (func == FUNC_LOAD) st_q <= S_LOAD;
					else begin
						cnt_q <= '0;
						bud_q <= ({25'd0, cycle_budget} > MAX_BUDGET) ? BW'(MAX_BUDGET)
							: BW'(cycle_budget);
						io_val_q <= io_read_value;
						io_stop_q <= io_write_stop;
						stop_q <= 1'b0;
						st_q <= S_CHK;
					end
				end
				S_LOAD: begin
					cnt_q <= '0;
					st_q <= S_END;
				end
				S_CHK: begin
					if (halted_q || stop_q || cnt_q >= bud_q) st_q <= S_END;
					else begin
						rd_addr_q <= pc_q[RW-1:0];
						back_q <= pc_q;
						st_q <= S_FETCH;
					end
				end
				S_FETCH: st_q <= S_OPW;
				S_OPW: begin
					op_q <= rom_rd;
					cnt_q <= cnt_q + BW'(op_cost(rom_rd));
					pc_q <= pc_q + 13'd1;
					rd_addr_q <= (rom_rd == OP_TRR) ? src_q[RW-1:0] : RW'(pc_q + 13'd1);
					opnd_q <= '0;
					unique case (rom_rd)
						OP_OR, OP_AND, OP_SED: begin nleft_q <= 2'd1; st_q <= S_OPR; end
						OP_JZ, OP_JC, OP_SES: begin nleft_q <= 2'd3; st_q <= S_OPR; end
						default: st_q <= S_DREQ;
					endcase
				end
				S_OPR: st_q <= S_OPW1;
				S_OPW1: begin
					opnd_q <= {opnd_q[7:0], rom_rd};
					pc_q <= pc_q + 13'd1;
					rd_addr_q <= RW'(pc_q + 13'd1);
					nleft_q <= nleft_q - 2'd1;
					st_q <= (nleft_q == 2'd1) ? S_EXEC : S_OPR;
				end
				S_DREQ: st_q <= S_EXEC;
				S_EXEC: begin
					unique case (op_q)
						OP_LDA: begin acc_q <= dval; z_q <= (dval == 4'd0); end
						OP_STA: if (is_io) begin
							kind <= KIND_WRITE;
							io_write_value <= acc_q; last <= 1'b0;
							stop_q <= io_stop_q;
						end
						OP_ADD: begin
							c_q <= sum[4]; acc_q <= sum[3:0];
							z_q <= (sum[3:0] == 4'd0);
						end
						OP_OR, OP_AND: begin
							acc_q <= res_acc; z_q <= (res_acc == 4'd0);
						end
						OP_NOT: begin acc_q <= ~acc_q; z_q <= (acc_q == 4'hF); end
						OP_SHL: begin
							c_q <= acc_q[3]; acc_q <= {acc_q[2:0], 1'b0};
							z_q <= (acc_q[2:0] == 3'd0);
						end
						OP_SHR: begin
							c_q <= acc_q[0]; acc_q <= {1'b0, acc_q[3:1]};
							z_q <= (acc_q[3:1] == 3'd0);
						end
						OP_PUA: sp_q <= (sp_q == SW'(STACK_DEPTH - 1)) ? '0 : sp_q + 1'b1;
						OP_POA: begin
							sp_q <= sp_dec; acc_q <= stk_rd; z_q <= (stk_rd == 4'd0);
						end
						OP_CMP: begin c_q <= (acc_q > dval); z_q <= (acc_q < dval); end
						OP_JZ, OP_JC: ;
						OP_SED: dp_q <= {4'd0, opnd_q[3:0]};
						OP_SES: src_q <= opnd_q;
						OP_TRR: begin
							src_q <= (13'(src_q) + 13'd1 >= 13'(ROM_DEPTH)) ? '0
								: src_q + 12'd1;
							z_q <= (rom_rd == 4'd0);
							if (is_io) begin
								kind <= KIND_WRITE;
								io_write_value <= rom_rd; last <= 1'b0;
							end
						end
					endcase
					// finish on a self-jump or on leaving the program store, unless a stopping store
					pc_q <= halt_now ? 13'(ROM_DEPTH) : pc_next;
					if (halt_now)
						halted_q <= 1'b1;
					st_q <= S_CHK;
				end
				S_END: begin
					kind <= KIND_END; io_write_value <= 4'd0;
					last <= 1'b1;
					st_q <= S_IDLE;
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end

	// end results show the registers; write events show zeros
	assign accumulator_out = (kind == KIND_END) ? acc_q : 4'd0;
	assign zero_out        = (kind == KIND_END) ? z_q : 1'b0;
	assign carry_out       = (kind == KIND_END) ? c_q : 1'b0;
	assign pc_out          = (kind == KIND_END) ? pc_q : 13'd0;
	assign done_res        = (kind == KIND_END) ? halted_q : 1'b0;
	assign cycles_used     = (kind == KIND_END) ? 7'(cnt_q) : 7'd0;

	`ASSERT_NEXT(a_start_busy, clk, arst_n, start && !busy, busy)
	`ASSERT_CLK(a_end_last, clk, arst_n, !(res_valid && kind == KIND_END) || last)
	`ASSERT_CLK(a_pc_range, clk, arst_n, busy || pc_q <= 13'(ROM_DEPTH))
endmodule

@@ src/ncpu_ram.sv @@
module ncpu_ram #(
	parameter int unsigned WIDTH = 4,
	parameter int unsigned DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule

@@ tb/tb_nibble_cpu_core.sv @@
`timescale 1ns / 100ps

module tb_nibble_cpu_core;
	import ncpu_pkg::*;

	localparam int ROM_NIBBLES  = 4096;
	localparam int DATA_NIBBLES = 256;
	localparam int STACK_SIZE = 64;
	localparam int BUDGET_CAP = 64;
	localparam int CYCLE_LIMIT = 1000000;
	localparam int SETTLE_CYCLES = 400;

	typedef struct packed {
		logic        func;
		logic [11:0] addr;
		logic [3:0]  nib;
		logic [6:0]  budget;
		logic [3:0]  io_val;
		logic        stop;
	} cmd_t;

	typedef struct packed {
		logic        kind;
		logic [3:0]  wval;
		logic        last_f;
		logic [3:0]  acc;
		logic        z;
		logic        c;
		logic [12:0] pc;
		logic        done;
		logic [6:0]  cyc;
	} res_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        io_wr_en = 1'b0;
	logic [7:0]  io_wr_data = '0;
	logic        start = 1'b0;
	logic        busy;
	logic        func = FUNC_LOAD;
	logic [11:0] load_address = '0;
	logic [3:0]  load_nibble = '0;
	logic [6:0]  cycle_budget = '0;
	logic [3:0]  io_read_value = '0;
	logic        io_write_stop = 1'b0;
	logic        res_valid;
	logic        kind;
	logic [3:0]  io_write_value;
	logic        last;
	logic [3:0]  accumulator_out;
	logic        zero_out;
	logic        carry_out;
	logic [12:0] pc_out;
	logic        done_res;
	logic [6:0]  cycles_used;

	nibble_cpu_core dut (
		.clk(clk), .arst_n(arst_n), .io_wr_en(io_wr_en), .io_wr_data(io_wr_data),
		.start(start), .busy(busy), .func(func), .load_address(load_address),
		.load_nibble(load_nibble), .cycle_budget(cycle_budget),
		.io_read_value(io_read_value), .io_write_stop(io_write_stop),
		.res_valid(res_valid), .kind(kind), .io_write_value(io_write_value),
		.last(last), .accumulator_out(accumulator_out), .zero_out(zero_out),
		.carry_out(carry_out), .pc_out(pc_out), .done_res(done_res),
		.cycles_used(cycles_used)
	);

	always #5 clk = ~clk;

	cmd_t cmd_queue[$];
	res_t pending_results[$];
	int   fail_count = 0;
	int   gap_left = 0;
	bit   idling_on = 1'b1;
	logic taken = 1'b0;
	int   tick_count = 0;

	// CPU state mirror
	logic [7:0]  io_addr_m = IO_ADDR_RST;
	logic [3:0]  acc_m = '0;
	logic        z_m = 1'b0;
	logic        c_m = 1'b0;
	int          pc_m = 0;
	logic [7:0]  dptr_m = '0;
	int          sptr_m = 0;
	int          src_m = 0;
	logic        halted_m = 1'b0;
	logic [3:0]  ram_m [DATA_NIBBLES];
	logic [3:0]  stack_m [STACK_SIZE];
	logic [3:0]  rom_m [ROM_NIBBLES];

	initial begin
		foreach (ram_m[i]) ram_m[i] = '0;
		foreach (stack_m[i]) stack_m[i] = '0;
		foreach (rom_m[i]) rom_m[i] = '0;
	end

	function automatic int instr_cost(logic [3:0] op);
		case (opcode_t'(op))
			OP_LDA, OP_STA, OP_NOT, OP_SHL, OP_SHR: return 2;
			OP_OR, OP_AND:                          return 3;
			OP_ADD, OP_PUA, OP_POA, OP_CMP:         return 4;
			OP_JZ, OP_JC:                           return 8;
			OP_SED:                                 return 5;
			OP_SES:                                 return 7;
			default:                                return 6;
		endcase
	endfunction

	function automatic logic [3:0] rom_at(int a);
		return rom_m[a % ROM_NIBBLES];
	endfunction

	function automatic int rom_word(int a);
		return int'({rom_at(a), rom_at(a + 1), rom_at(a + 2)});
	endfunction

	function automatic logic [3:0] data_read(logic [3:0] io_val);
		return (dptr_m == io_addr_m) ? io_val : ram_m[dptr_m];
	endfunction

	function automatic void push_result(logic k, logic [3:0] wv, logic lst, bit snap,
			int cyc);
		res_t r;
		r = '0;
		r.kind = k;
		r.wval = wv;
		r.last_f = lst;
		if (snap) begin
			r.acc = acc_m;
			r.z = z_m;
			r.c = c_m;
			r.pc = pc_m[12:0];
			r.done = halted_m;
			r.cyc = cyc[6:0];
		end
		pending_results.push_back(r);
	endfunction

	// Work out every result one accepted command produces
	function automatic void emulate_item(cmd_t cm);
		int budget, count, back, v;
		logic [3:0] op;
		bit stop_run;
		if (cm.func == FUNC_LOAD) begin
			rom_m[cm.addr] = cm.nib;
			push_result(KIND_END, 4'd0, 1'b1, 1'b1, 0);
			return;
		end
		budget = (int'(cm.budget) > BUDGET_CAP) ? BUDGET_CAP : int'(cm.budget);
		count = 0;
		while (!halted_m && count < budget) begin
			back = pc_m;
			op = rom_at(pc_m);
			pc_m++;
			count += instr_cost(op);
			stop_run = 1'b0;
			case (opcode_t'(op))
				OP_LDA: begin
					acc_m = data_read(cm.io_val);
					z_m = (acc_m == 0);
				end
				OP_STA: begin
					ram_m[dptr_m] = acc_m;
					if (dptr_m == io_addr_m) begin
						push_result(KIND_WRITE, acc_m, 1'b0, 1'b0, 0);
						stop_run = cm.stop;
					end
				end
				OP_ADD: begin
					v = int'(acc_m) + int'(data_read(cm.io_val));
					c_m = (v > 15);
					acc_m = v[3:0];
					z_m = (acc_m == 0);
				end
				OP_OR: begin
					acc_m |= rom_at(pc_m);
					pc_m++;
					z_m = (acc_m == 0);
				end
				OP_AND: begin
					acc_m &= rom_at(pc_m);
					pc_m++;
					z_m = (acc_m == 0);
				end
				OP_NOT: begin
					acc_m = ~acc_m;
					z_m = (acc_m == 0);
				end
				OP_SHL: begin
					c_m = acc_m[3];
					acc_m = acc_m << 1;
					z_m = (acc_m == 0);
				end
				OP_SHR: begin
					c_m = acc_m[0];
					acc_m = acc_m >> 1;
					z_m = (acc_m == 0);
				end
				OP_PUA: begin
					stack_m[sptr_m] = acc_m;
					sptr_m = (sptr_m + 1) % STACK_SIZE;
				end
				OP_POA: begin
					sptr_m = (sptr_m == 0) ? STACK_SIZE - 1 : sptr_m - 1;
					acc_m = stack_m[sptr_m];
					z_m = (acc_m == 0);
				end
				OP_CMP: begin
					v = int'(data_read(cm.io_val));
					c_m = (int'(acc_m) > v);
					z_m = (int'(acc_m) < v);
				end
				OP_JZ, OP_JC: begin
					v = rom_word(pc_m);
					pc_m += 3;
					if ((op == OP_JZ) ? z_m : c_m) pc_m = v;
				end
				OP_SED: begin
					dptr_m = {4'd0, rom_at(pc_m)};
					pc_m++;
				end
				OP_SES: begin
					src_m = rom_word(pc_m);
					pc_m += 3;
				end
				default: begin
					v = int'(rom_at(src_m));
					src_m++;
					if (src_m >= ROM_NIBBLES) src_m = 0;
					ram_m[dptr_m] = v[3:0];
					if (dptr_m == io_addr_m) push_result(KIND_WRITE, v[3:0], 1'b0, 1'b0, 0);
					z_m = (v == 0);
				end
			endcase
			if (stop_run) break;
			if (back == pc_m || pc_m >= ROM_NIBBLES) begin
				pc_m = ROM_NIBBLES;
				halted_m = 1'b1;
			end
		end
		push_result(KIND_END, 4'd0, 1'b1, 1'b1, count);
	endfunction

	// Drive the next command at the falling edge once the last one is taken
	always @(negedge clk) begin
		cmd_t cm;
		if (!start || taken) begin
			if (gap_left > 0) begin
				gap_left--;
				start <= 1'b0;
			end else if (cmd_queue.size() > 0) begin
				cm = cmd_queue.pop_front();
				start <= 1'b1;
				func <= cm.func;
				load_address <= cm.addr;
				load_nibble <= cm.nib;
				cycle_budget <= cm.budget;
				io_read_value <= cm.io_val;
				io_write_stop <= cm.stop;
				if (idling_on && $urandom_range(0, 4) == 0) gap_left = $urandom_range(1, 4);
			end else begin
				start <= 1'b0;
			end
		end
	end

	// Record accepted transactions and configuration writes, check results
	always @(posedge clk) begin
		cmd_t cm;
		res_t got, want;
		taken <= start && !busy;
		if (arst_n && io_wr_en) io_addr_m = io_wr_data;
		if (arst_n && res_valid) begin
			got = {kind, io_write_value, last, accumulator_out, zero_out, carry_out,
				pc_out, done_res, cycles_used};
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected result, expected none, actual %h", $time, got);
				fail_count++;
			end else begin
				want = pending_results.pop_front();
				if (got !== want) begin
					$display(
						"%0t: expected kind=%0d wv=%0d last=%0d acc=%0d z=%0d c=%0d pc=%0d done=%0d cyc=%0d",
						$time, want.kind, want.wval, want.last_f, want.acc, want.z,
						want.c, want.pc, want.done, want.cyc);
					$display(
						"%0t: actual   kind=%0d wv=%0d last=%0d acc=%0d z=%0d c=%0d pc=%0d done=%0d cyc=%0d",
						$time, got.kind, got.wval, got.last_f, got.acc, got.z,
						got.c, got.pc, got.done, got.cyc);
					fail_count++;
				end
			end
		end
		if (arst_n && start && !busy) begin
			cm = {func, load_address, load_nibble, cycle_budget, io_read_value, io_write_stop};
			emulate_item(cm);
		end
	end

	// Abort a hung run
	always @(posedge clk) begin
		tick_count++;
		if (tick_count > CYCLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	task automatic queue_load(int a, logic [3:0] n);
		cmd_t cm;
		cm = '0;
		cm.func = FUNC_LOAD;
		cm.addr = a[11:0];
		cm.nib = n;
		cm.budget = 7'($urandom);
		cm.io_val = 4'($urandom);
		cm.stop = 1'($urandom);
		cmd_queue.push_back(cm);
	endtask

	task automatic queue_run(int budget, logic [3:0] io_val, logic stop);
		cmd_t cm;
		cm = '0;
		cm.func = FUNC_RUN;
		cm.addr = 12'($urandom);
		cm.nib = 4'($urandom);
		cm.budget = budget[6:0];
		cm.io_val = io_val;
		cm.stop = stop;
		cmd_queue.push_back(cm);
	endtask

	task automatic queue_image(int base, logic [3:0] img[$]);
		foreach (img[i]) queue_load(base + i, img[i]);
	endtask

	// Hold until every transaction is answered and the core has settled
	task automatic drain();
		do @(posedge clk);
		while (cmd_queue.size() > 0 || start || pending_results.size() > 0 || busy);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_io_addr(logic [7:0] a);
		@(negedge clk);
		io_wr_en <= 1'b1;
		io_wr_data <= a;
		@(negedge clk);
		io_wr_en <= 1'b0;
	endtask

	// Random program that loops back to the start via AND 0 / JZ 000
	task automatic random_phase(int runs);
		logic [3:0] img[$];
		int len, target, pos;
		logic [3:0] op;
		img = {};
		len = $urandom_range(12, 28);
		while (img.size() < len) begin
			pos = img.size();
			op = 4'($urandom);
			img.push_back(op);
			case (opcode_t'(op))
				OP_OR, OP_AND, OP_SED: img.push_back(4'($urandom));
				OP_JZ, OP_JC: begin
					do target = $urandom_range(0, len - 1);
					while (target == pos);
					img.push_back(target[11:8]);
					img.push_back(target[7:4]);
					img.push_back(target[3:0]);
				end
				OP_SES: begin
					img.push_back(4'($urandom));
					img.push_back(4'($urandom));
					img.push_back(4'($urandom));
				end
				default: ;
			endcase
		end
		img.push_back(OP_AND);
		img.push_back(4'd0);
		img.push_back(OP_JZ);
		img.push_back(4'd0);
		img.push_back(4'd0);
		img.push_back(4'd0);
		queue_image(0, img);
		repeat (runs) begin
			case ($urandom_range(0, 19))
				0:       queue_run(0, 4'($urandom), 1'($urandom));
				1, 2:    queue_run($urandom_range(65, 127), 4'($urandom), 1'($urandom));
				3:       queue_load($urandom, 4'($urandom));
				default: queue_run($urandom_range(1, 64), 4'($urandom), 1'($urandom));
			endcase
		end
	endtask

	initial begin
		logic [3:0] img[$];
		repeat (10) @(negedge clk);
		arst_n <= 1'b1;
		wait (!busy);
		@(negedge clk);

		// Directed: every opcode, port access, stack wrap, TRR wrap, budget extremes
		set_io_addr(8'd3);
		img = {OP_SED, 4'd3, OP_LDA, OP_ADD, OP_STA, OP_OR, 4'hF, OP_AND, 4'h0,
			OP_NOT, OP_SHL, OP_SHR, OP_PUA, OP_POA, OP_POA, OP_CMP,
			OP_SES, 4'hF, 4'hF, 4'hE, OP_TRR, OP_TRR, OP_TRR,
			OP_JC, 4'd0, 4'd0, 4'd0, OP_AND, 4'd0, OP_JZ, 4'd0, 4'd0, 4'd0};
		queue_image(0, img);
		queue_load(4094, 4'd3);
		queue_load(4095, 4'hC);
		queue_run(0, 4'h0, 1'b0);
		queue_run(1, 4'hF, 1'b0);
		queue_run(64, 4'h9, 1'b1);
		queue_run(127, 4'h0, 1'b0);
		queue_run(64, 4'h7, 1'b0);
		queue_run(64, 4'hF, 1'b1);
		drain();

		set_io_addr(8'd0);
		random_phase(20);
		drain();
		set_io_addr(8'd15);
		random_phase(20);
		drain();
		set_io_addr(8'd255);
		random_phase(15);
		drain();

		idling_on = 1'b0;
		set_io_addr(8'd7);
		random_phase(15);
		drain();

		// Run off the end of the program store, then run twice more after the finish
		queue_load(4094, OP_NOT);
		queue_load(4095, OP_NOT);
		queue_image(0, '{OP_AND, 4'd0, OP_JZ, 4'hF, 4'hF, 4'hE});
		queue_run(64, 4'h0, 1'b0);
		queue_run(64, 4'h0, 1'b0);
		queue_run(64, 4'h5, 1'b1);
		drain();

		if (fail_count == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end
endmodule

@@ sim.f @@
+incdir+src
src/ncpu_pkg.sv
src/ncpu_ram.sv
src/nibble_cpu_core.sv
tb/tb_nibble_cpu_core.sv
